// ----- design/rmq_pkg.sv -----
// ============================================================================
// rmq_pkg
// Shared widths, types and constants of the rotation matrix to quaternion core.
// ============================================================================
package rmq_pkg;

    localparam int FRAC_BITS = 30;                  // fraction bits of Q2.30
    localparam int DW        = 32;                  // port field width
    localparam int VW        = 36;                  // signed raw vector element
    localparam int MW        = VW - 1;              // raw magnitude
    localparam int SW        = 31;                  // normalized magnitude
    localparam int NORM_MSB  = SW - 1;              // target MSB of the largest
    localparam int PW        = $clog2(MW);          // MSB position width
    localparam int SQW       = 2 * SW;              // one square
    localparam int XW        = 64;                  // sum of squares
    localparam int NW        = XW / 2;              // integer square root
    localparam int REMW      = NW + 2;              // square root remainder
    localparam int DVW       = SW + FRAC_BITS + 1;  // rounded dividend
    localparam int QB        = DVW - NORM_MSB;      // quotient bits
    localparam int NCOMP     = 4;

    // Diagonal axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [VW-1:0] ONE_V   = VW'(64'd1 << FRAC_BITS);
    localparam logic [DW-1:0]        ONE_OUT = DW'(64'd1 << FRAC_BITS);

    typedef logic [SW-1:0]               smag_t;
    typedef logic [NCOMP-1:0][QB-1:0]    quot_t;

    // Sideband that rides along the square root pipeline
    typedef struct packed {
        logic [NCOMP-1:0]        neg;
        logic                    degen;
        logic [NCOMP-1:0][SW-1:0] mag;
    } sq_side_t;

    // Sideband that rides along the divider pipeline
    typedef struct packed {
        logic [NCOMP-1:0] neg;
        logic             degen;
    } dv_side_t;

endpackage

// ----- design/rmq_isqrt.sv -----
// ============================================================================
// rmq_isqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module rmq_isqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [rmq_pkg::XW-1:0] in_x,
    input  rmq_pkg::sq_side_t     in_side,
    output logic                  out_valid,
    output logic [rmq_pkg::NW-1:0] out_root,
    output rmq_pkg::sq_side_t     out_side
);

    localparam int NS = rmq_pkg::NW;

    logic                      valid_reg [NS];
    logic [rmq_pkg::REMW-1:0]  rem_reg   [NS];
    logic [rmq_pkg::NW-1:0]    root_reg  [NS];
    logic [rmq_pkg::XW-1:0]    x_reg     [NS];
    rmq_pkg::sq_side_t         side_reg  [NS];

    logic                      valid_in [NS];
    logic [rmq_pkg::REMW-1:0]  rem_in   [NS];
    logic [rmq_pkg::NW-1:0]    root_in  [NS];
    logic [rmq_pkg::XW-1:0]    x_in     [NS];
    rmq_pkg::sq_side_t         side_in  [NS];

    assign valid_in[0] = in_valid;
    assign rem_in[0]   = '0;
    assign root_in[0]  = '0;
    assign x_in[0]     = in_x;
    assign side_in[0]  = in_side;

    for (genvar t = 0; t < NS; t++) begin : g_stage
        logic [rmq_pkg::REMW+1:0] cur;
        logic [rmq_pkg::REMW+1:0] trial;
        logic                     take;

        if (t > 0) begin : g_link
            assign valid_in[t] = valid_reg[t-1];
            assign rem_in[t]   = rem_reg[t-1];
            assign root_in[t]  = root_reg[t-1];
            assign x_in[t]     = x_reg[t-1];
            assign side_in[t]  = side_reg[t-1];
        end

        assign cur   = {rem_in[t], x_in[t][rmq_pkg::XW-1 -: 2]};
        assign trial = {2'b00, root_in[t], 2'b01};
        assign take  = cur >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t] <= 1'b0;
            end else if (en) begin
                valid_reg[t] <= valid_in[t];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[t]  <= take ? rmq_pkg::REMW'(cur - trial) : rmq_pkg::REMW'(cur);
                root_reg[t] <= {root_in[t][rmq_pkg::NW-2:0], take};
                x_reg[t]    <= {x_in[t][rmq_pkg::XW-3:0], 2'b00};
                side_reg[t] <= side_in[t];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- design/rmq_div.sv -----
// ============================================================================
// rmq_div
// Four-lane pipelined restoring divider with round-to-nearest dividend.
// ============================================================================
module rmq_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [rmq_pkg::NW-1:0] in_n,
    input  rmq_pkg::sq_side_t      in_side,
    output logic                   out_valid,
    output rmq_pkg::quot_t         out_q,
    output rmq_pkg::dv_side_t      out_side
);

    localparam int NS = rmq_pkg::QB;
    localparam int RW = rmq_pkg::NW;

    // Dividend stage: mag << FRAC_BITS plus half the divisor
    logic                                  pre_valid_reg;
    logic [rmq_pkg::NW-1:0]                pre_n_reg;
    logic [rmq_pkg::NCOMP-1:0][rmq_pkg::DVW-1:0] pre_d_reg;
    rmq_pkg::dv_side_t                     pre_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_n_reg          <= in_n;
            pre_side_reg.neg   <= in_side.neg;
            pre_side_reg.degen <= in_side.degen;
            for (int c = 0; c < rmq_pkg::NCOMP; c++) begin
                pre_d_reg[c] <= (rmq_pkg::DVW'(in_side.mag[c]) << rmq_pkg::FRAC_BITS)
                              + rmq_pkg::DVW'(in_n >> 1);
            end
        end
    end

    logic                                     valid_reg [NS];
    logic [rmq_pkg::NW-1:0]                   n_reg     [NS];
    logic [rmq_pkg::NCOMP-1:0][RW-1:0]        rem_reg   [NS];
    logic [rmq_pkg::NCOMP-1:0][NS-1:0]        qlo_reg   [NS];
    rmq_pkg::dv_side_t                        side_reg  [NS];

    logic                                     valid_in [NS];
    logic [rmq_pkg::NW-1:0]                   n_in     [NS];
    logic [rmq_pkg::NCOMP-1:0][RW-1:0]        rem_in   [NS];
    logic [rmq_pkg::NCOMP-1:0][NS-1:0]        qlo_in   [NS];
    rmq_pkg::dv_side_t                        side_in  [NS];

    assign valid_in[0] = pre_valid_reg;
    assign n_in[0]     = pre_n_reg;
    assign side_in[0]  = pre_side_reg;
    for (genvar c = 0; c < rmq_pkg::NCOMP; c++) begin : g_init
        assign rem_in[0][c] = RW'(pre_d_reg[c][rmq_pkg::DVW-1:NS]);
        assign qlo_in[0][c] = pre_d_reg[c][NS-1:0];
    end

    for (genvar t = 0; t < NS; t++) begin : g_stage
        logic [rmq_pkg::NCOMP-1:0][RW:0] cur;
        logic [rmq_pkg::NCOMP-1:0]       take;

        if (t > 0) begin : g_link
            assign valid_in[t] = valid_reg[t-1];
            assign n_in[t]     = n_reg[t-1];
            assign rem_in[t]   = rem_reg[t-1];
            assign qlo_in[t]   = qlo_reg[t-1];
            assign side_in[t]  = side_reg[t-1];
        end

        for (genvar c = 0; c < rmq_pkg::NCOMP; c++) begin : g_lane
            assign cur[c]  = {rem_in[t][c], qlo_in[t][c][NS-1]};
            assign take[c] = cur[c] >= {1'b0, n_in[t]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t] <= 1'b0;
            end else if (en) begin
                valid_reg[t] <= valid_in[t];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[t]    <= n_in[t];
                side_reg[t] <= side_in[t];
                for (int c = 0; c < rmq_pkg::NCOMP; c++) begin
                    rem_reg[t][c] <= take[c] ? RW'(cur[c] - {1'b0, n_in[t]}) : RW'(cur[c]);
                    qlo_reg[t][c] <= {qlo_in[t][c][NS-2:0], take[c]};
                end
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_q     = qlo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- design/rotation_matrix_to_quaternion_core.sv -----
// ============================================================================
// rotation_matrix_to_quaternion_core
// Rotation matrix (Q2.30) to unit quaternion (Q2.30) by the trace/diagonal
// method, fully pipelined.
// ============================================================================
// Pipeline from the input transaction to m_valid: 6 front stages,
//   32 square root stages, 1 dividend stage, 32 divider stages, 1 output.
// Throughput: one matrix per cycle unless m_ready stalls the output; the square
//   root and divider pipelines take one result bit per stage, so depth follows their bit counts.
// Reset: aresetn clears every valid bit; data registers keep their contents.
// ============================================================================
module rotation_matrix_to_quaternion_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [rmq_pkg::DW-1:0] s_m00,
    input  logic signed [rmq_pkg::DW-1:0] s_m01,
    input  logic signed [rmq_pkg::DW-1:0] s_m02,
    input  logic signed [rmq_pkg::DW-1:0] s_m10,
    input  logic signed [rmq_pkg::DW-1:0] s_m11,
    input  logic signed [rmq_pkg::DW-1:0] s_m12,
    input  logic signed [rmq_pkg::DW-1:0] s_m20,
    input  logic signed [rmq_pkg::DW-1:0] s_m21,
    input  logic signed [rmq_pkg::DW-1:0] s_m22,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [rmq_pkg::DW-1:0] m_qw,
    output logic signed [rmq_pkg::DW-1:0] m_qx,
    output logic signed [rmq_pkg::DW-1:0] m_qy,
    output logic signed [rmq_pkg::DW-1:0] m_qz,
    output logic                    m_status
);

    localparam int VW = rmq_pkg::VW;
    localparam int MW = rmq_pkg::MW;
    localparam int SW = rmq_pkg::SW;
    localparam int NC = rmq_pkg::NCOMP;

    // Whole pipeline advances whenever the output register can take a result;
    // the output register itself acts as the skid stage.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------------
    // Stage 1: trace, leading axis and the unnormalized vector (w, x, y, z)
    // ------------------------------------------------------------------------
    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [VW-1:0] trace, rad;
    logic signed [VW-1:0] v_next [NC];
    logic [1:0]           axis;

    assign e00 = VW'(s_m00);
    assign e01 = VW'(s_m01);
    assign e02 = VW'(s_m02);
    assign e10 = VW'(s_m10);
    assign e11 = VW'(s_m11);
    assign e12 = VW'(s_m12);
    assign e20 = VW'(s_m20);
    assign e21 = VW'(s_m21);
    assign e22 = VW'(s_m22);

    assign trace = e00 + e11 + e22;

    // Ties keep the lower axis
    always_comb begin
        axis = (e11 > e00) ? rmq_pkg::AXIS_Y : rmq_pkg::AXIS_X;
        if (e22 > ((e11 > e00) ? e11 : e00)) begin
            axis = rmq_pkg::AXIS_Z;
        end
    end

    always_comb begin
        if (trace > 0) begin
            rad       = trace + rmq_pkg::ONE_V;
            v_next[0] = rad;
            v_next[1] = e21 - e12;
            v_next[2] = e02 - e20;
            v_next[3] = e10 - e01;
        end else begin
            case (axis)
                rmq_pkg::AXIS_Y: begin
                    rad       = e11 - e22 - e00 + rmq_pkg::ONE_V;
                    v_next[0] = e02 - e20;
                    v_next[1] = e01 + e10;
                    v_next[2] = rad;
                    v_next[3] = e21 + e12;
                end
                rmq_pkg::AXIS_Z: begin
                    rad       = e22 - e00 - e11 + rmq_pkg::ONE_V;
                    v_next[0] = e10 - e01;
                    v_next[1] = e02 + e20;
                    v_next[2] = e12 + e21;
                    v_next[3] = rad;
                end
                default: begin
                    rad       = e00 - e11 - e22 + rmq_pkg::ONE_V;
                    v_next[0] = e21 - e12;
                    v_next[1] = rad;
                    v_next[2] = e10 + e01;
                    v_next[3] = e20 + e02;
                end
            endcase
        end
    end

    logic                 s1_valid_reg;
    logic signed [VW-1:0] s1_v_reg [NC];
    logic                 s1_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_v_reg   <= v_next;
            s1_bad_reg <= (rad <= 0);   // non-positive radicand
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: magnitudes, signs and the largest magnitude
    // ------------------------------------------------------------------------
    logic [MW-1:0] mag2 [NC];
    logic [MW-1:0] big01, big23, big2;
    logic [NC-1:0] neg2;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            neg2[c] = s1_v_reg[c][VW-1];
            mag2[c] = neg2[c] ? MW'(-s1_v_reg[c]) : MW'(s1_v_reg[c]);
        end
    end

    assign big01 = (mag2[1] > mag2[0]) ? mag2[1] : mag2[0];
    assign big23 = (mag2[3] > mag2[2]) ? mag2[3] : mag2[2];
    assign big2  = (big23 > big01) ? big23 : big01;

    logic          s2_valid_reg;
    logic [MW-1:0] s2_mag_reg [NC];
    logic [NC-1:0] s2_neg_reg;
    logic [MW-1:0] s2_big_reg;
    logic          s2_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_mag_reg   <= mag2;
            s2_neg_reg   <= neg2;
            s2_big_reg   <= big2;
            s2_degen_reg <= s1_bad_reg || (big2 == '0);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: MSB position of the largest magnitude
    // ------------------------------------------------------------------------
    logic [rmq_pkg::PW-1:0] msb3;

    always_comb begin
        msb3 = '0;
        for (int b = 0; b < MW; b++) begin
            if (s2_big_reg[b]) begin
                msb3 = rmq_pkg::PW'(b);
            end
        end
    end

    logic                   s3_valid_reg;
    logic [MW-1:0]          s3_mag_reg [NC];
    logic [NC-1:0]          s3_neg_reg;
    logic [rmq_pkg::PW-1:0] s3_msb_reg;
    logic                   s3_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_mag_reg   <= s2_mag_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_msb_reg   <= msb3;
            s3_degen_reg <= s2_degen_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: block scaling so the largest lands at bit NORM_MSB
    // ------------------------------------------------------------------------
    localparam logic [rmq_pkg::PW-1:0] NORM_POS = rmq_pkg::PW'(rmq_pkg::NORM_MSB);

    rmq_pkg::smag_t smag4 [NC];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (s3_msb_reg > NORM_POS) begin
                smag4[c] = SW'(s3_mag_reg[c] >> (s3_msb_reg - NORM_POS));
            end else begin
                smag4[c] = SW'(s3_mag_reg[c] << (NORM_POS - s3_msb_reg));
            end
        end
    end

    logic           s4_valid_reg;
    rmq_pkg::smag_t s4_mag_reg [NC];
    logic [NC-1:0]  s4_neg_reg;
    logic           s4_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_mag_reg   <= smag4;
            s4_neg_reg   <= s3_neg_reg;
            s4_degen_reg <= s3_degen_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: squares
    // ------------------------------------------------------------------------
    logic                      s5_valid_reg;
    logic [rmq_pkg::SQW-1:0]   s5_sq_reg [NC];
    rmq_pkg::smag_t            s5_mag_reg [NC];
    logic [NC-1:0]             s5_neg_reg;
    logic                      s5_degen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < NC; c++) begin
                s5_sq_reg[c] <= rmq_pkg::SQW'(s4_mag_reg[c]) * rmq_pkg::SQW'(s4_mag_reg[c]);
            end
            s5_mag_reg   <= s4_mag_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_degen_reg <= s4_degen_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: sum of squares, packed with the sideband for the root pipeline
    // ------------------------------------------------------------------------
    logic                    s6_valid_reg;
    logic [rmq_pkg::XW-1:0]  s6_sum_reg;
    rmq_pkg::sq_side_t       s6_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_sum_reg <= rmq_pkg::XW'(s5_sq_reg[0]) + rmq_pkg::XW'(s5_sq_reg[1])
                        + rmq_pkg::XW'(s5_sq_reg[2]) + rmq_pkg::XW'(s5_sq_reg[3]);
            s6_side_reg.neg   <= s5_neg_reg;
            s6_side_reg.degen <= s5_degen_reg;
            for (int c = 0; c < NC; c++) begin
                s6_side_reg.mag[c] <= s5_mag_reg[c];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Norm: floor(sqrt(sum))
    // ------------------------------------------------------------------------
    logic                    sq_valid;
    logic [rmq_pkg::NW-1:0]  sq_root;
    rmq_pkg::sq_side_t       sq_side;

    rmq_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_x      (s6_sum_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ------------------------------------------------------------------------
    // Per-component rounded division by the norm
    // ------------------------------------------------------------------------
    logic              dv_valid;
    rmq_pkg::quot_t    dv_q;
    rmq_pkg::dv_side_t dv_side;

    rmq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_n      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // ------------------------------------------------------------------------
    // Output stage: sign, saturation, identity on degenerate input
    // ------------------------------------------------------------------------
    localparam logic [rmq_pkg::DW:0] POS_MAX = {2'b00, {(rmq_pkg::DW-1){1'b1}}};
    localparam logic [rmq_pkg::DW:0] NEG_LIM = {2'b01, {(rmq_pkg::DW-1){1'b0}}};

    logic [rmq_pkg::DW-1:0] q_next [NC];

    always_comb begin
        logic [rmq_pkg::DW:0] qe;
        qe = '0;
        for (int c = 0; c < NC; c++) begin
            qe = (rmq_pkg::DW+1)'(dv_q[c]);
            if (dv_side.neg[c] && (qe != '0)) begin
                q_next[c] = (qe >= NEG_LIM) ? NEG_LIM[rmq_pkg::DW-1:0]
                                            : rmq_pkg::DW'(-qe);
            end else begin
                q_next[c] = (qe > POS_MAX) ? POS_MAX[rmq_pkg::DW-1:0]
                                           : rmq_pkg::DW'(qe);
            end
        end
    end

    logic                   out_valid_reg;
    logic [rmq_pkg::DW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic                   status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dv_side.degen) begin
                qw_reg     <= rmq_pkg::ONE_OUT;
                qx_reg     <= '0;
                qy_reg     <= '0;
                qz_reg     <= '0;
                status_reg <= 1'b1;
            end else begin
                qw_reg     <= q_next[0];
                qx_reg     <= q_next[1];
                qy_reg     <= q_next[2];
                qz_reg     <= q_next[3];
                status_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_qw     = qw_reg;
    assign m_qx     = qx_reg;
    assign m_qy     = qy_reg;
    assign m_qz     = qz_reg;
    assign m_status = status_reg;

endmodule

// ----- design/rmq_checker.sv -----
// ============================================================================
// rmq_checker
// Port-level checks of the rotation matrix to quaternion core.
// ============================================================================
module rmq_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [rmq_pkg::DW-1:0]  m_qw,
    input logic [rmq_pkg::DW-1:0]  m_qx,
    input logic [rmq_pkg::DW-1:0]  m_qy,
    input logic [rmq_pkg::DW-1:0]  m_qz,
    input logic                    m_status
);

    // Held result stays put until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_qw) && $stable(m_qx)
                               && $stable(m_qy) && $stable(m_qz) && $stable(m_status))
        else $error("result changed while stalled");

    // A stalled output backs up the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // Degenerate status always carries the identity
    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_qw == rmq_pkg::ONE_OUT && m_qx == '0
                                && m_qy == '0 && m_qz == '0)
        else $error("degenerate result is not identity");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_qw     (m_qw),
    .m_qx     (m_qx),
    .m_qy     (m_qy),
    .m_qz     (m_qz),
    .m_status (m_status)
);
